### rtl/i2crm_pkg.sv
`default_nettype none

package i2crm_pkg;

  // Write FIFO geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_FW    = $clog2(FIFO_DEPTH + 1);

  // Acknowledge timeout after reset, in ticks.
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd50;

  // Direction bit of the device address byte.
  localparam logic [7:0] DEV_RD_BIT = 8'h01;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_PUSH  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Which byte of the transaction is on the wire.
  typedef enum logic [1:0] {
    STG_DEV  = 2'd0,
    STG_MEM  = 2'd1,
    STG_RD   = 2'd2,
    STG_DATA = 2'd3
  } stage_t;

  // Bus sequencer phases, one-hot.
  typedef enum logic [18:0] {
    P_IDLE = 19'd1 << 0,
    P_S0   = 19'd1 << 1,
    P_S1   = 19'd1 << 2,
    P_S2   = 19'd1 << 3,
    P_TX_A = 19'd1 << 4,
    P_TX_B = 19'd1 << 5,
    P_TX_C = 19'd1 << 6,
    P_AK_A = 19'd1 << 7,
    P_AK_B = 19'd1 << 8,
    P_AK_S = 19'd1 << 9,
    P_RX_A = 19'd1 << 10,
    P_RX_B = 19'd1 << 11,
    P_MA_A = 19'd1 << 12,
    P_MA_B = 19'd1 << 13,
    P_MA_C = 19'd1 << 14,
    P_WANT = 19'd1 << 15,
    P_SP0  = 19'd1 << 16,
    P_SP1  = 19'd1 << 17,
    P_SP2  = 19'd1 << 18
  } phase_t;

endpackage

`default_nettype wire

### rtl/i2c_register_master_top.sv
`default_nettype none
// Latency: the result for an item is registered at the edge that accepts it and is
// offered on the output channel from the next cycle on.
// Throughput: one item per cycle while out_tready is high; the single output register
// frees itself in the same cycle that its result is taken, so both move every cycle.
// Reset (rst_n low at a clock edge) returns the sequencer to idle, lines high and
// ack_timeout to 50; the write FIFO contents stay undefined until bytes are pushed.
module i2c_register_master_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: ack_timeout.
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata from bit 0: sda_in(1), dev_addr(8), mem_addr(8), use_mem_addr(1),
  // is_read(1), byte_count(8), tx_data(8), zero fill(5).
  input  wire logic [39:0] in_tdata,
  // tuser: op(2).
  input  wire logic [1:0]  in_tuser,
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata from bit 0: scl(1), sda_out(1), sda_drive(1), rx_data(8), rx_valid(1),
  // busy_res(1), done_res(1), status(1), wants_byte(1).
  output logic [15:0]      out_tdata,
  // tlast: rx_last.
  output logic             out_tlast
);
  import i2crm_pkg::*;

  // Input fields.
  op_t        in_op;
  logic       in_sda;
  logic [7:0] in_dev_addr;
  logic [7:0] in_mem_addr;
  logic       in_use_mem;
  logic       in_is_read;
  logic [7:0] in_byte_count;
  logic [7:0] in_tx_data;
  logic       in_acc;

  assign in_op         = op_t'(in_tuser);
  assign in_sda        = in_tdata[0];
  assign in_dev_addr   = in_tdata[8:1];
  assign in_mem_addr   = in_tdata[16:9];
  assign in_use_mem    = in_tdata[17];
  assign in_is_read    = in_tdata[18];
  assign in_byte_count = in_tdata[26:19];
  assign in_tx_data    = in_tdata[34:27];

  // Sequencer state.
  phase_t             phase_r, phase_nxt;
  stage_t             stage_r, stage_nxt;
  logic [3:0]         bit_index_r, bit_index_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [7:0]         bytes_left_r, bytes_left_nxt;
  logic [7:0]         wait_count_r, wait_count_nxt;
  logic [7:0]         dev_addr_r, dev_addr_nxt;
  logic [7:0]         mem_addr_r, mem_addr_nxt;
  logic               use_mem_r, use_mem_nxt;
  logic               is_read_r, is_read_nxt;
  logic               err_r, err_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               drive_r, drive_nxt;
  logic [7:0]         ack_timeout_r;

  // Write FIFO: circular buffer with head pointer and fill count.
  logic [7:0]         fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_r, head_nxt;
  logic [FIFO_FW-1:0] fill_r, fill_nxt;
  logic [FIFO_FW:0]   wr_sum;
  logic [FIFO_AW-1:0] wr_idx;
  logic               fifo_wr;
  logic               fifo_full;

  // Per-item results.
  logic               rx_valid_nxt;
  logic               rx_last_nxt;
  logic [7:0]         rx_data_nxt;
  logic               done_nxt;

  // Shared "fetch next data byte" step and its byte count.
  logic               do_next;
  logic [7:0]         nd_bl;
  logic [7:0]         bl_dec;
  logic [8:0]         wait_inc;

  // Output register.
  logic               out_valid_r;
  logic               o_scl_r, o_sda_r, o_drive_r;
  logic [7:0]         o_rx_data_r;
  logic               o_rx_valid_r, o_rx_last_r;
  logic               o_busy_r, o_done_r, o_status_r, o_wants_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign fifo_full = (fill_r == FIFO_FW'(FIFO_DEPTH));
  assign wr_sum    = (FIFO_FW + 1)'(head_r) + (FIFO_FW + 1)'(fill_r);
  assign wr_idx    = (wr_sum >= (FIFO_FW + 1)'(FIFO_DEPTH))
                   ? FIFO_AW'(wr_sum - (FIFO_FW + 1)'(FIFO_DEPTH))
                   : FIFO_AW'(wr_sum);

  assign bl_dec   = (bytes_left_r != 8'd0) ? bytes_left_r - 8'd1 : bytes_left_r;
  assign wait_inc = {1'b0, wait_count_r} + 9'd1;

  always_comb begin
    phase_nxt      = phase_r;
    stage_nxt      = stage_r;
    bit_index_nxt  = bit_index_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    wait_count_nxt = wait_count_r;
    dev_addr_nxt   = dev_addr_r;
    mem_addr_nxt   = mem_addr_r;
    use_mem_nxt    = use_mem_r;
    is_read_nxt    = is_read_r;
    err_nxt        = err_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    drive_nxt      = drive_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    fifo_wr        = 1'b0;
    rx_valid_nxt   = 1'b0;
    rx_last_nxt    = 1'b0;
    rx_data_nxt    = 8'd0;
    done_nxt       = 1'b0;
    do_next        = 1'b0;
    nd_bl          = bytes_left_r;

    if (in_acc) begin
      unique case (in_op)
        OP_BEGIN: begin
          if (phase_r == P_IDLE) begin
            dev_addr_nxt   = in_dev_addr;
            mem_addr_nxt   = in_mem_addr;
            use_mem_nxt    = in_use_mem;
            is_read_nxt    = in_is_read;
            bytes_left_nxt = in_byte_count;
            wait_count_nxt = 8'd0;
            err_nxt        = 1'b0;
            stage_nxt      = STG_DEV;
            phase_nxt      = P_S0;
          end
        end
        OP_PUSH: begin
          if (!fifo_full) begin
            fifo_wr  = 1'b1;
            fill_nxt = fill_r + FIFO_FW'(1);
          end
        end
        OP_TICK: begin
          unique case (phase_r)
            P_S0: begin
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
              drive_nxt = 1'b1;
              phase_nxt = P_S1;
            end
            P_S1: begin
              sda_nxt   = 1'b0;
              phase_nxt = P_S2;
            end
            P_S2: begin
              scl_nxt       = 1'b0;
              shift_nxt     = (stage_r == STG_RD) ? (dev_addr_r | DEV_RD_BIT)
                                                  : (dev_addr_r & ~DEV_RD_BIT);
              bit_index_nxt = 4'd0;
              phase_nxt     = P_TX_A;
            end
            P_TX_A: begin
              drive_nxt = 1'b1;
              scl_nxt   = 1'b0;
              sda_nxt   = shift_r[7];
              phase_nxt = P_TX_B;
            end
            P_TX_B: begin
              scl_nxt   = 1'b1;
              phase_nxt = P_TX_C;
            end
            P_TX_C: begin
              scl_nxt       = 1'b0;
              shift_nxt     = {shift_r[6:0], 1'b0};
              bit_index_nxt = bit_index_r + 4'd1;
              phase_nxt     = (bit_index_r >= 4'd7) ? P_AK_A : P_TX_A;
            end
            P_AK_A: begin
              drive_nxt = 1'b0;
              scl_nxt   = 1'b0;
              phase_nxt = P_AK_B;
            end
            P_AK_B: begin
              scl_nxt        = 1'b1;
              wait_count_nxt = 8'd0;
              phase_nxt      = P_AK_S;
            end
            P_AK_S: begin
              if (!in_sda) begin
                scl_nxt = 1'b0;
                unique case (stage_r)
                  STG_DEV: begin
                    if (use_mem_r) begin
                      stage_nxt     = STG_MEM;
                      shift_nxt     = mem_addr_r;
                      bit_index_nxt = 4'd0;
                      phase_nxt     = P_TX_A;
                    end else if (is_read_r) begin
                      stage_nxt = STG_RD;
                      phase_nxt = P_S0;
                    end else begin
                      do_next = 1'b1;
                    end
                  end
                  STG_MEM: begin
                    if (is_read_r) begin
                      stage_nxt = STG_RD;
                      phase_nxt = P_S0;
                    end else begin
                      do_next = 1'b1;
                    end
                  end
                  STG_RD: begin
                    if (bytes_left_r == 8'd0) begin
                      phase_nxt = P_SP0;
                    end else begin
                      shift_nxt     = 8'd0;
                      bit_index_nxt = 4'd0;
                      phase_nxt     = P_RX_A;
                    end
                  end
                  STG_DATA: begin
                    do_next = 1'b1;
                    nd_bl   = bl_dec;
                  end
                  default: ;
                endcase
              end else if (wait_inc >= {1'b0, ack_timeout_r}) begin
                // Slave never pulled SDA low: abort with STOP.
                err_nxt   = 1'b1;
                phase_nxt = P_SP0;
              end else begin
                wait_count_nxt = wait_inc[7:0];
              end
            end
            P_RX_A: begin
              scl_nxt   = 1'b0;
              drive_nxt = 1'b0;
              phase_nxt = P_RX_B;
            end
            P_RX_B: begin
              scl_nxt       = 1'b1;
              shift_nxt     = {shift_r[6:0], in_sda};
              bit_index_nxt = bit_index_r + 4'd1;
              if (bit_index_r >= 4'd7) begin
                rx_valid_nxt = 1'b1;
                rx_data_nxt  = {shift_r[6:0], in_sda};
                rx_last_nxt  = (bytes_left_r == 8'd1);
                phase_nxt    = P_MA_A;
              end else begin
                phase_nxt = P_RX_A;
              end
            end
            P_MA_A: begin
              // ACK every byte but the last, which is NACKed.
              scl_nxt   = 1'b0;
              drive_nxt = 1'b1;
              sda_nxt   = !(bytes_left_r > 8'd1);
              phase_nxt = P_MA_B;
            end
            P_MA_B: begin
              scl_nxt   = 1'b1;
              phase_nxt = P_MA_C;
            end
            P_MA_C: begin
              scl_nxt        = 1'b0;
              bytes_left_nxt = bl_dec;
              if (bl_dec == 8'd0) begin
                phase_nxt = P_SP0;
              end else begin
                shift_nxt     = 8'd0;
                bit_index_nxt = 4'd0;
                phase_nxt     = P_RX_A;
              end
            end
            P_WANT: begin
              if (fill_r != FIFO_FW'(0)) begin
                do_next = 1'b1;
              end
            end
            P_SP0: begin
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
              drive_nxt = 1'b1;
              phase_nxt = P_SP1;
            end
            P_SP1: begin
              scl_nxt   = 1'b1;
              phase_nxt = P_SP2;
            end
            P_SP2: begin
              sda_nxt   = 1'b1;
              done_nxt  = 1'b1;
              phase_nxt = P_IDLE;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // Move on to the next write data byte: pop the FIFO, stall for it, or STOP when none is left.
    if (do_next) begin
      stage_nxt      = STG_DATA;
      bytes_left_nxt = nd_bl;
      if (nd_bl == 8'd0) begin
        phase_nxt = P_SP0;
      end else if (fill_r != FIFO_FW'(0)) begin
        shift_nxt     = fifo_mem_r[head_r];
        bit_index_nxt = 4'd0;
        phase_nxt     = P_TX_A;
        head_nxt      = (head_r == FIFO_AW'(FIFO_DEPTH - 1)) ? FIFO_AW'(0)
                                                             : head_r + FIFO_AW'(1);
        fill_nxt      = fill_r - FIFO_FW'(1);
      end else begin
        phase_nxt = P_WANT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= P_IDLE;
      stage_r       <= STG_DEV;
      bit_index_r   <= 4'd0;
      shift_r       <= 8'd0;
      bytes_left_r  <= 8'd0;
      wait_count_r  <= 8'd0;
      dev_addr_r    <= 8'd0;
      mem_addr_r    <= 8'd0;
      use_mem_r     <= 1'b0;
      is_read_r     <= 1'b0;
      err_r         <= 1'b0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      drive_r       <= 1'b1;
      head_r        <= '0;
      fill_r        <= '0;
      ack_timeout_r <= ACK_TIMEOUT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      stage_r      <= stage_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      wait_count_r <= wait_count_nxt;
      dev_addr_r   <= dev_addr_nxt;
      mem_addr_r   <= mem_addr_nxt;
      use_mem_r    <= use_mem_nxt;
      is_read_r    <= is_read_nxt;
      err_r        <= err_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      drive_r      <= drive_nxt;
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
      if (cfg_we) begin
        ack_timeout_r <= cfg_wdata;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: FIFO storage and the result item.
  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo_mem_r[wr_idx] <= in_tx_data;
    end
    if (in_acc) begin
      o_scl_r      <= scl_nxt;
      o_sda_r      <= sda_nxt;
      o_drive_r    <= drive_nxt;
      o_rx_data_r  <= rx_data_nxt;
      o_rx_valid_r <= rx_valid_nxt;
      o_rx_last_r  <= rx_last_nxt;
      o_busy_r     <= (phase_nxt != P_IDLE);
      o_done_r     <= done_nxt;
      o_status_r   <= err_nxt;
      o_wants_r    <= (phase_nxt == P_WANT);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_wants_r, o_status_r, o_done_r, o_busy_r, o_rx_valid_r,
                       o_rx_data_r, o_drive_r, o_sda_r, o_scl_r};
  assign out_tlast  = o_rx_last_r;

  // The FIFO never counts more bytes than it holds.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FIFO_FW'(FIFO_DEPTH))
    else $error("write FIFO fill count overflow");

  // Every accepted item leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");

  // A finished transaction is no longer busy.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_done_r) |-> !o_busy_r)
    else $error("done reported while still busy");

  // A received byte is always followed by the master acknowledge slot.
  a_rx_then_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && rx_valid_nxt) |=> (phase_r == P_MA_A))
    else $error("received byte not followed by acknowledge");

  // A stall for write data only happens inside a transaction.
  a_want_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_wants_r) |-> (o_busy_r && stage_r == STG_DATA))
    else $error("write stall outside a write data phase");

endmodule

`default_nettype wire
